// ----- hdl/urfp_pkg.sv -----
`timescale 1ns / 1ps

package urfp_pkg;

   localparam int ByteWidth   = 8;
   localparam int DigitWidth  = 6;
   localparam int OffsetWidth = 6;
   localparam int MaskWidth   = 10;
   localparam int RangeWidth  = 34;
   localparam int NumRanges   = 4;

   localparam logic [ByteWidth-1:0] HeaderChar = 8'h6D;   // 'm'
   localparam logic [ByteWidth-1:0] CharZero   = 8'h30;   // '0'
   localparam logic [ByteWidth-1:0] CharNine   = 8'h39;
   localparam logic [ByteWidth-1:0] CharLowA   = 8'h61;   // 'a'
   localparam logic [ByteWidth-1:0] CharLowZ   = 8'h7A;
   localparam logic [ByteWidth-1:0] CharUpA    = 8'h41;   // 'A'
   localparam logic [ByteWidth-1:0] CharUpZ    = 8'h5A;
   localparam logic [DigitWidth-1:0] LetterBase = 6'd10;

   // frame offsets, header byte is offset 0
   localparam logic [OffsetWidth-1:0] OffType     = 6'd1;
   localparam logic [OffsetWidth-1:0] OffMaskHi   = 6'd3;
   localparam logic [OffsetWidth-1:0] OffMaskLo   = 6'd4;
   localparam logic [OffsetWidth-1:0] OffTag      = 6'd60;
   localparam logic [OffsetWidth-1:0] OffAnchor   = 6'd62;
   localparam logic [OffsetWidth-1:0] OffLast     = 6'd63;
   localparam int                     RangeFirst  = 6;
   localparam int                     RangeStride = 9;
   localparam int                     RangeDigits = 8;

   localparam int RspFieldBits = ByteWidth + MaskWidth + NumRanges * RangeWidth
                                 + 2 * DigitWidth;
   localparam int RspDataWidth = ((RspFieldBits + 7) / 8) * 8;

   typedef struct packed {
      logic [DigitWidth-1:0]  anchor_id;
      logic [DigitWidth-1:0]  tag_id;
      logic [RangeWidth-1:0]  range_three;
      logic [RangeWidth-1:0]  range_two;
      logic [RangeWidth-1:0]  range_one;
      logic [RangeWidth-1:0]  range_zero;
      logic [MaskWidth-1:0]   anchor_mask;
      logic [ByteWidth-1:0]   msg_type;
   } report_type;

   typedef struct packed {
      logic                   in_frame;
      logic                   frame_last;
      logic [OffsetWidth-1:0] offset;
   } core_status_type;

   function automatic logic [DigitWidth-1:0] char_value(input logic [ByteWidth-1:0] c);
      logic [DigitWidth-1:0] v;
      v = '0;
      if (c >= CharZero && c <= CharNine) begin
         v = DigitWidth'(c - CharZero);
      end else if (c >= CharLowA && c <= CharLowZ) begin
         v = DigitWidth'(c - CharLowA) + LetterBase;
      end else if (c >= CharUpA && c <= CharUpZ) begin
         v = DigitWidth'(c - CharUpA) + LetterBase;
      end
      return v;
   endfunction

endpackage

// ----- hdl/uwb_ascii_range_frame_parser.sv -----
`timescale 1ns / 1ps

// ASCII range-report frame parser.
// Slave stream req_*: one received character per request in req_tdata[7:0].
// Bytes are dropped until an 'm'; that byte and the 63 that follow form a
// frame, and after the last one a single report request goes out on rsp_*.
// The report carries the type byte, the two-digit anchor mask, four
// eight-digit ranges (integers, units of 0.001), the tag id and anchor id.
// Throughput: one byte per cycle, except while the last frame byte waits for
// the report register; set by the update of the frame accumulators between
// the input register and the report register. rsp_tvalid rises once the last
// frame byte has been taken into the input register and the report register
// has then loaded the report.
// A stalled report is held in the report register while the next frame is
// collected; only the last byte of that next frame waits for rsp_tready.
// Reset (synchronous, active high) empties both registers and returns the
// parser to hunting with all fields cleared.
module uwb_ascii_range_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] msg_type, [17:8] anchor_mask, [51:18] range_zero,
   // [85:52] range_one, [119:86] range_two, [153:120] range_three,
   // [159:154] tag_id, [165:160] anchor_id, [167:166] zero
   output logic [urfp_pkg::RspDataWidth-1:0] rsp_tdata
);
   import urfp_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff, in_byte_in;
   logic                 step;
   logic                 report_load;
   report_type           report;
   report_type           rsp_report;
   core_status_type      status;

   // the last byte of a frame waits until the report register has room
   assign step        = in_valid_ff && (!status.frame_last || !rsp_tvalid || rsp_tready);
   assign report_load = step && status.frame_last;
   assign req_tready  = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   urfp_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .report  (report),
      .status  (status)
   );

   urfp_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (report_load),
      .report     (report),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_report (rsp_report)
   );

   assign rsp_tdata = {{(RspDataWidth - RspFieldBits){1'b0}}, rsp_report};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      report_load |-> (!rsp_tvalid || rsp_tready))
      else $error("report register overwritten while full");

   a_hunt_after_report: assert property (@(posedge clock) disable iff (reset)
      report_load |=> (!status.in_frame && rsp_tvalid))
      else $error("parser still in frame after report");

   a_hunt_offset: assert property (@(posedge clock) disable iff (reset)
      !status.in_frame |-> (status.offset == '0))
      else $error("nonzero offset while hunting");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !req_tready) |-> (status.frame_last && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a pending report");

endmodule

// ----- hdl/urfp_parse_core.sv -----
`timescale 1ns / 1ps

module urfp_parse_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [urfp_pkg::ByteWidth-1:0] rx_byte,
   output urfp_pkg::report_type          report,
   output urfp_pkg::core_status_type     status
);
   import urfp_pkg::*;

   logic                   in_frame_ff, in_frame_in;
   logic [OffsetWidth-1:0] offset_ff, offset_in;
   logic [ByteWidth-1:0]   type_ff, type_in;
   logic [MaskWidth-1:0]   mask_ff, mask_in;
   logic [RangeWidth-1:0]  range_ff [NumRanges];
   logic [RangeWidth-1:0]  range_in [NumRanges];
   logic [DigitWidth-1:0]  tag_ff, tag_in;
   logic [DigitWidth-1:0]  anchor_ff, anchor_in;
   logic [NumRanges-1:0]   range_hit;
   logic [DigitWidth-1:0]  digit;
   logic                   frame_last;

   assign digit      = char_value(rx_byte);
   assign frame_last = in_frame_ff && (offset_ff == OffLast);

   always_comb begin
      for (int k = 0; k < NumRanges; k++) begin
         range_hit[k] = (offset_ff >= OffsetWidth'(RangeFirst + RangeStride * k)) &&
                        (offset_ff <  OffsetWidth'(RangeFirst + RangeStride * k + RangeDigits));
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      offset_in   = offset_ff;
      type_in     = type_ff;
      mask_in     = mask_ff;
      range_in    = range_ff;
      tag_in      = tag_ff;
      anchor_in   = anchor_ff;
      if (step) begin
         if (!in_frame_ff) begin
            if (rx_byte == HeaderChar) begin
               in_frame_in = 1'b1;
               offset_in   = OffType;
               type_in     = '0;
               mask_in     = '0;
               tag_in      = '0;
               anchor_in   = '0;
               for (int k = 0; k < NumRanges; k++) begin
                  range_in[k] = '0;
               end
            end
         end else begin
            unique case (offset_ff) inside
               OffType:              type_in   = rx_byte;
               OffMaskHi, OffMaskLo: mask_in   = {mask_ff[MaskWidth-5:0], 4'b0000}
                                                 + MaskWidth'(digit);
               OffTag:               tag_in    = digit;
               OffAnchor:            anchor_in = digit;
               default: begin
                  for (int k = 0; k < NumRanges; k++) begin
                     if (range_hit[k]) begin
                        range_in[k] = {range_ff[k][RangeWidth-5:0], 4'b0000}
                                      + RangeWidth'(digit);
                     end
                  end
               end
            endcase
            if (frame_last) begin
               in_frame_in = 1'b0;
               offset_in   = '0;
            end else begin
               offset_in = offset_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         offset_ff   <= '0;
         type_ff     <= '0;
         mask_ff     <= '0;
         tag_ff      <= '0;
         anchor_ff   <= '0;
         for (int k = 0; k < NumRanges; k++) begin
            range_ff[k] <= '0;
         end
      end else begin
         in_frame_ff <= in_frame_in;
         offset_ff   <= offset_in;
         type_ff     <= type_in;
         mask_ff     <= mask_in;
         tag_ff      <= tag_in;
         anchor_ff   <= anchor_in;
         range_ff    <= range_in;
      end
   end

   // offset 63 updates no field, so the held values are the report
   always_comb begin
      report.msg_type    = type_ff;
      report.anchor_mask = mask_ff;
      report.range_zero  = range_ff[0];
      report.range_one   = range_ff[1];
      report.range_two   = range_ff[2];
      report.range_three = range_ff[3];
      report.tag_id      = tag_ff;
      report.anchor_id   = anchor_ff;
   end

   assign status.in_frame   = in_frame_ff;
   assign status.frame_last = frame_last;
   assign status.offset     = offset_ff;

endmodule

// ----- hdl/urfp_rsp_reg.sv -----
`timescale 1ns / 1ps

module urfp_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  urfp_pkg::report_type report,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output urfp_pkg::report_type rsp_report
);
   import urfp_pkg::*;

   logic       valid_ff, valid_in;
   report_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = report;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_report = data_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import urfp_pkg::*;

   typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_type;
   typedef enum logic [1:0] {STYLE_RANDOM, STYLE_HIGH, STYLE_LOW, STYLE_JUNK} frame_style_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = '0;   // [7:0] rx_byte
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;         // report_type fields, msg_type lowest

   // reports the parser still owes, oldest first
   report_type owed_reports[$];

   // mirror of the parser state
   logic                   collecting = 1'b0;
   logic [OffsetWidth-1:0] cur_offset = '0;
   report_type             partial    = '0;
   logic [RangeWidth-1:0]  range_acc[NumRanges];

   rx_mode_type rx_mode  = RX_ALWAYS;
   int       hold_len    = 0;
   int       hold_ticket = 0;
   int       hold_seen   = 0;
   int       hold_left   = 0;
   int       rx_cycle    = 0;
   bit       tx_gaps     = 1'b1;
   int       burst_left  = 1;

   int errors        = 0;
   int n_bytes       = 0;
   int n_frame_bytes = 0;
   int n_reports     = 0;
   int n_checked     = 0;

   uwb_ascii_range_frame_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [DigitWidth-1:0] digit_of(input logic [7:0] c);
      if (c >= CharZero && c <= CharNine) begin
         return DigitWidth'(c - CharZero);
      end
      if (c >= CharLowA && c <= CharLowZ) begin
         return DigitWidth'(c - CharLowA) + LetterBase;
      end
      if (c >= CharUpA && c <= CharUpZ) begin
         return DigitWidth'(c - CharUpA) + LetterBase;
      end
      return '0;
   endfunction

   // advance the mirror by one accepted byte; queues a report on the last frame byte
   function automatic void parse_byte(input logic [7:0] b);
      logic [DigitWidth-1:0] d;
      d = digit_of(b);
      if (!collecting) begin
         if (b == HeaderChar) begin
            partial = '0;
            foreach (range_acc[k]) range_acc[k] = '0;
            collecting    = 1'b1;
            cur_offset    = OffType;
            n_frame_bytes++;
         end
         return;
      end
      n_frame_bytes++;
      if (cur_offset == OffType) begin
         partial.msg_type = b;
      end else if (cur_offset == OffMaskHi || cur_offset == OffMaskLo) begin
         partial.anchor_mask = MaskWidth'({partial.anchor_mask, 4'h0} + d);
      end else if (cur_offset == OffTag) begin
         partial.tag_id = d;
      end else if (cur_offset == OffAnchor) begin
         partial.anchor_id = d;
      end else begin
         for (int k = 0; k < NumRanges; k++) begin
            if (cur_offset >= RangeFirst + RangeStride * k &&
                cur_offset <  RangeFirst + RangeStride * k + RangeDigits) begin
               range_acc[k] = RangeWidth'({range_acc[k], 4'h0} + d);
            end
         end
      end
      if (cur_offset == OffLast) begin
         partial.range_zero  = range_acc[0];
         partial.range_one   = range_acc[1];
         partial.range_two   = range_acc[2];
         partial.range_three = range_acc[3];
         owed_reports.push_back(partial);
         n_reports++;
         collecting = 1'b0;
         cur_offset = '0;
      end else begin
         cur_offset++;
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // report checker
   always @(posedge clock) begin
      report_type got;
      report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = report_type'(rsp_tdata[RspFieldBits-1:0]);
         if (owed_reports.size() == 0) begin
            $error("report request with none outstanding");
            errors++;
         end else begin
            want = owed_reports.pop_front();
            n_checked++;
            check_field("msg_type", want.msg_type, got.msg_type);
            check_field("anchor_mask", want.anchor_mask, got.anchor_mask);
            check_field("range_zero", want.range_zero, got.range_zero);
            check_field("range_one", want.range_one, got.range_one);
            check_field("range_two", want.range_two, got.range_two);
            check_field("range_three", want.range_three, got.range_three);
            check_field("tag_id", want.tag_id, got.tag_id);
            check_field("anchor_id", want.anchor_id, got.anchor_id);
         end
      end
   end

   // receiver: long hold-offs on request, otherwise the current stall pattern
   always @(posedge clock) begin
      rx_cycle++;
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= ($urandom_range(0, 9) >= 3);
            default:   rsp_tready <= (rx_cycle % 7 < 3);
         endcase
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_bytes++;
      parse_byte(b);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 48);
         gap = tx_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // sender goes quiet until every owed report has come back
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (owed_reports.size() != 0);
   endtask

   task automatic send_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         do b = 8'($urandom); while (b == HeaderChar);
         send_byte(b);
      end
   endtask

   // characters just outside the digit and letter ranges, plus 8'h00 and 8'hFF
   function automatic logic [7:0] junk_char(input int i);
      case (i)
         0:       return 8'(CharZero - 1);
         1:       return 8'(CharNine + 1);
         2:       return 8'(CharUpA - 1);
         3:       return 8'(CharUpZ + 1);
         4:       return 8'(CharLowA - 1);
         5:       return 8'(CharLowZ + 1);
         6:       return 8'h00;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'(CharZero + $urandom_range(0, 9));
         3, 4:    return 8'(CharLowA + $urandom_range(0, 25));
         5, 6:    return 8'(CharUpA + $urandom_range(0, 25));
         7:       return junk_char($urandom_range(0, 7));
         8:       return 8'($urandom);
         default: return HeaderChar;
      endcase
   endfunction

   task automatic send_frame(input frame_style_type style);
      logic [7:0] b;
      send_byte(HeaderChar);
      for (int o = 1; o <= OffLast; o++) begin
         case (style)
            STYLE_HIGH: b = (o == OffType) ? 8'hFF : (o[0] ? CharLowZ : CharUpZ);
            STYLE_LOW:  b = (o == OffType) ? 8'h00 : CharZero;
            // 'm' as type byte is plain data inside a frame
            STYLE_JUNK: b = (o == OffType) ? HeaderChar : junk_char(o % 8);
            default:    b = (o == OffType) ? 8'($urandom) : pick_char();
         endcase
         send_byte(b);
      end
   endtask

   task automatic test_directed();
      rx_mode <= RX_ALWAYS;
      tx_gaps = 1'b0;
      send_noise(4);
      send_frame(STYLE_HIGH);
      // back to back: header must clear what the previous frame left
      send_frame(STYLE_LOW);
      send_noise(3);
      send_frame(STYLE_JUNK);
      send_frame(STYLE_RANDOM);
      drain_reports();
   endtask

   task automatic test_backpressure();
      drain_reports();
      tx_gaps = 1'b0;
      hold_len    <= 400;
      hold_ticket <= hold_ticket + 1;
      // first report parks in the output register, second frame stalls on its last byte
      repeat (3) send_frame(STYLE_RANDOM);
      drain_reports();
      rx_mode     <= RX_RANDOM;
      tx_gaps     = 1'b1;
      hold_len    <= 250;
      hold_ticket <= hold_ticket + 1;
      repeat (2) send_frame(STYLE_RANDOM);
      drain_reports();
   endtask

   task automatic test_random_frames();
      while (n_bytes < 1650) begin
         if ($urandom_range(0, 3) == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 2));
         end
         tx_gaps = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 11))
            0:       send_noise($urandom_range(1, 6));
            1:       drain_reports();
            2:       send_frame(frame_style_type'($urandom_range(1, 3)));
            default: send_frame(STYLE_RANDOM);
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_frames();
      drain_reports();
      repeat (20) @(posedge clock);
      $display("%0d bytes sent, %0d inside frames, %0d reports checked",
               n_bytes, n_frame_bytes, n_checked);
      $display("covered: extreme, junk and random frames, noise between frames, output stalls");
      if (errors == 0 && owed_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/urfp_pkg.sv
hdl/urfp_parse_core.sv
hdl/urfp_rsp_reg.sv
hdl/uwb_ascii_range_frame_parser.sv
tb/tb_top.sv
